[hw/rtl/rspr_pkg.sv]
// ----------------------------------------------------------------------------
// rspr_pkg
// Shared types, character codes and helpers for the RSP packet receiver.
// ----------------------------------------------------------------------------
package rspr_pkg;

	localparam logic [7:0] START_CHAR  = 8'h24;
	localparam logic [7:0] END_CHAR    = 8'h23;
	localparam logic [7:0] ESC_CHAR    = 8'h7d;
	localparam logic [7:0] ESC_ADD     = 8'h20;
	localparam logic [7:0] ACK_GOOD    = 8'h2b;
	localparam logic [7:0] ACK_BAD     = 8'h2d;
	localparam logic [7:0] BAD_CKSUM   = 8'hff;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_PAYLOAD = 3'd1,
		PH_ESCAPED = 3'd2,
		PH_CK_HIGH = 3'd3,
		PH_CK_LOW  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] item_kind;
		logic [7:0] data_byte;
		logic [7:0] received_sum;
		logic [7:0] computed_sum;
	} out_item_t;

	// hex digit decode: bit 4 set flags a character that is not a hex digit
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b0, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b0, 4'(c - 8'h57)};
		end else begin
			r = 5'h1f;
		end
		return r;
	endfunction

endpackage

[hw/rtl/rspr_stream_if.sv]
// ----------------------------------------------------------------------------
// rspr_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface rspr_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/rsp_packet_receiver_top.sv]
// ----------------------------------------------------------------------------
// rsp_packet_receiver_top
// A byte that yields a result is registered in byte_s1, then in item_s2, which drives res.
// Throughput: one byte per cycle while the result side keeps taking.
// Reset (arst_n, async, active low): hunting for '$', sum and digit zero,
// both pipeline stages empty.
// ----------------------------------------------------------------------------
module rsp_packet_receiver_top
	import rspr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rspr_stream_if.sink   rx,
	rspr_stream_if.source res
);

	// Two registers: byte_s1 holds the accepted byte, item_s2 holds the result.
	// The parser's state advances only as the s1 byte moves on, so the frame
	// state stays in step with what has been delivered. A result waiting in
	// s2 still lets one more byte land in s1 (that is the skid).
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	out_item_t  item_s2;
	logic       advance;
	logic       step;
	logic       has_item;
	out_item_t  item;

	// s2 can be refilled when empty or when its transaction completes now
	assign advance  = !valid_s2 || res.ready;
	assign step     = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) byte_s1 <= rx.payload.rx_byte;
	end

	rspr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.rx_byte  (byte_s1),
		.has_item (has_item),
		.item     (item)
	);

	// result register: bytes with no result (hunting, escape, '#', high
	// digit) simply leave s2 empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step && has_item;
		end
	end

	always_ff @(posedge clk) begin
		if (step && has_item) item_s2 <= item;
	end

	assign res.valid   = valid_s2;
	assign res.payload = item_s2;

	// backpressure only ever comes from a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> valid_s1 && valid_s2 && !res.ready)
		else $error("input stalled without a stalled result");

	a_payload_sums_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && item_s2.item_kind == KIND_PAYLOAD |->
		item_s2.received_sum == 8'h00 && item_s2.computed_sum == 8'h00)
		else $error("payload transaction carries checksum fields");

	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && item_s2.item_kind != KIND_PAYLOAD |->
		(item_s2.item_kind == KIND_GOOD) ==
		(item_s2.received_sum == item_s2.computed_sum)
		&& item_s2.data_byte == ((item_s2.item_kind == KIND_GOOD) ? ACK_GOOD : ACK_BAD))
		else $error("frame end verdict or ack inconsistent");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> item_s2.item_kind != 2'd3)
		else $error("unused result kind");

endmodule

[hw/rtl/rspr_parser.sv]
// ----------------------------------------------------------------------------
// rspr_parser
// Frame state machine, running checksum and per-byte result decode.
// ----------------------------------------------------------------------------
module rspr_parser
	import rspr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output logic       has_item,
	output out_item_t  item
);

	phase_t     phase_q, phase_d;
	logic [7:0] running_sum_q, running_sum_d;
	logic [3:0] high_digit_q, high_digit_d;
	logic [4:0] hex;
	logic [7:0] rx_sum;
	logic       good;

	assign hex    = hex_decode(rx_byte);
	assign rx_sum = hex[4] ? BAD_CKSUM : {high_digit_q, hex[3:0]};
	assign good   = (rx_sum == running_sum_q);

	// next state
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_PAYLOAD: begin
				if (rx_byte == END_CHAR) phase_d = PH_CK_HIGH;
				else if (rx_byte == ESC_CHAR) phase_d = PH_ESCAPED;
			end
			PH_ESCAPED: phase_d = PH_PAYLOAD;
			PH_CK_HIGH: phase_d = PH_CK_LOW;
			PH_CK_LOW:  phase_d = PH_HUNT;
			default: begin
				phase_d = (rx_byte == START_CHAR) ? PH_PAYLOAD : PH_HUNT;
			end
		endcase
	end

	// sum and checksum digit
	always_comb begin
		running_sum_d = running_sum_q;
		high_digit_d  = high_digit_q;
		unique case (phase_q)
			PH_PAYLOAD: begin
				if (rx_byte != END_CHAR) running_sum_d = running_sum_q + rx_byte;
			end
			PH_ESCAPED: running_sum_d = running_sum_q + rx_byte;
			PH_CK_HIGH: high_digit_d = hex[3:0];
			PH_CK_LOW:  ;
			default: begin
				if (rx_byte == START_CHAR) running_sum_d = '0;
			end
		endcase
	end

	// outputs
	always_comb begin
		has_item = 1'b0;
		item     = '0;
		unique case (phase_q)
			PH_PAYLOAD: begin
				has_item       = (rx_byte != END_CHAR) && (rx_byte != ESC_CHAR);
				item.item_kind = KIND_PAYLOAD;
				item.data_byte = rx_byte;
			end
			PH_ESCAPED: begin
				has_item       = 1'b1;
				item.item_kind = KIND_PAYLOAD;
				item.data_byte = rx_byte + ESC_ADD;
			end
			PH_CK_LOW: begin
				has_item          = 1'b1;
				item.item_kind    = good ? KIND_GOOD : KIND_BAD;
				item.data_byte    = good ? ACK_GOOD : ACK_BAD;
				item.received_sum = rx_sum;
				item.computed_sum = running_sum_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			running_sum_q <= '0;
			high_digit_q  <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			running_sum_q <= running_sum_d;
			high_digit_q  <= high_digit_d;
		end
	end

	a_ck_low_returns: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_CK_LOW |=> phase_q == PH_HUNT)
		else $error("parser did not return to hunting after checksum");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_HUNT && rx_byte == START_CHAR |=>
		running_sum_q == 8'h00 && phase_q == PH_PAYLOAD)
		else $error("start character did not open a clean frame");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(running_sum_q))
		else $error("parser state moved without a byte");

endmodule

[test/rsp_packet_receiver_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_packet_receiver_top_tb
// Self-checking bench for the RSP packet receiver. Raw link bytes go in as
// framed packets with random payloads, escapes, good and bad checksums, and
// noise between frames. A scoreboard tracks the framing state itself, queues
// the expected payload and frame end transactions, and checks every result
// field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module rsp_packet_receiver_top_tb;
	import rspr_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned FRAMED_TARGET = 650;
	localparam int unsigned LONG_HOLD     = 120;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned HOLD_AT       = 200;
	localparam int unsigned PAUSE_AT      = 450;

	// result-side stall patterns
	localparam int SINK_ALWAYS   = 0;
	localparam int SINK_HALF     = 1;
	localparam int SINK_SPARSE   = 2;
	localparam int SINK_PERIODIC = 3;

	// Opening sequence, byte by byte:
	//  - two noise bytes while hunting, at both extremes
	//  - a frame with 0xff, a '$' as plain data, an escaped '#', an escaped
	//    escape and an escaped 0xff that wraps; checksum "39" is correct
	//  - a frame with mixed-case hex digits "aB", correct
	//  - an empty frame whose high digit 'G' is not hex (reads as F)
	//  - an empty frame whose low digit '/' is not hex (value 0xff)
	localparam logic [7:0] DIRECTED [27] = '{
		8'h00, 8'hff,
		START_CHAR, 8'hff, START_CHAR, ESC_CHAR, END_CHAR, ESC_CHAR, ESC_CHAR,
		ESC_CHAR, 8'hff, END_CHAR, 8'h33, 8'h39,
		START_CHAR, 8'hab, END_CHAR, 8'h61, 8'h42,
		START_CHAR, END_CHAR, 8'h47, 8'h30,
		START_CHAR, END_CHAR, 8'h30, 8'h2f
	};

	// Tracks the framing state of the link and holds the transactions that
	// the block still owes on its result channel.
	class rsp_frame_scoreboard;
		out_item_t   owed_q[$];
		phase_t      phase       = PH_HUNT;
		logic [7:0]  running_sum = '0;
		logic [3:0]  high_digit  = '0;
		int unsigned mismatches  = 0;
		int unsigned payload_seen = 0;
		int unsigned good_seen   = 0;
		int unsigned bad_seen    = 0;

		// {not_hex, value}; letters share their low nibble with the digit
		function logic [4:0] hex_digit(input logic [7:0] c);
			logic [4:0] r;
			r = 5'h1f;
			if (c inside {[8'h30:8'h39]}) begin
				r = {1'b0, c[3:0]};
			end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
				r = {1'b0, 4'(c[3:0] + 4'd9)};
			end
			return r;
		endfunction

		function void owe(input kind_t kind, input logic [7:0] data,
				input logic [7:0] rsum, input logic [7:0] csum);
			out_item_t t;
			t.item_kind    = kind;
			t.data_byte    = data;
			t.received_sum = rsum;
			t.computed_sum = csum;
			owed_q.push_back(t);
		endfunction

		// called for every byte the block accepts
		function void note_byte(input logic [7:0] b);
			logic [4:0] d;
			logic [7:0] rx;
			case (phase)
				PH_PAYLOAD: begin
					if (b == END_CHAR) begin
						phase = PH_CK_HIGH;
					end else begin
						running_sum = running_sum + b;
						if (b == ESC_CHAR) begin
							phase = PH_ESCAPED;
						end else begin
							owe(KIND_PAYLOAD, b, '0, '0);
						end
					end
				end
				PH_ESCAPED: begin
					// always data, even '#', '$' or another escape
					running_sum = running_sum + b;
					phase = PH_PAYLOAD;
					owe(KIND_PAYLOAD, 8'(b + ESC_ADD), '0, '0);
				end
				PH_CK_HIGH: begin
					d = hex_digit(b);
					high_digit = d[3:0];
					phase = PH_CK_LOW;
				end
				PH_CK_LOW: begin
					d = hex_digit(b);
					rx = d[4] ? BAD_CKSUM : {high_digit, d[3:0]};
					if (rx == running_sum) begin
						owe(KIND_GOOD, ACK_GOOD, rx, running_sum);
					end else begin
						owe(KIND_BAD, ACK_BAD, rx, running_sum);
					end
					phase = PH_HUNT;
				end
				default: begin
					if (b == START_CHAR) begin
						running_sum = '0;
						phase = PH_PAYLOAD;
					end else begin
						phase = PH_HUNT;
					end
				end
			endcase
		endfunction

		task report_mismatch(input string what);
			mismatches++;
			$display("MISMATCH @%0t: %s", $time, what);
		endtask

		task compare_field(input string name, input logic [7:0] got,
				input logic [7:0] want);
			if (got !== want) begin
				report_mismatch($sformatf("%s got %02h, expected %02h", name, got, want));
			end
		endtask

		task check_result(input out_item_t got);
			out_item_t want;
			if (owed_q.size() == 0) begin
				report_mismatch($sformatf("unexpected transaction kind %0d data %02h",
					got.item_kind, got.data_byte));
				return;
			end
			want = owed_q.pop_front();
			compare_field("item_kind", 8'(got.item_kind), 8'(want.item_kind));
			compare_field("data_byte", got.data_byte, want.data_byte);
			compare_field("received_sum", got.received_sum, want.received_sum);
			compare_field("computed_sum", got.computed_sum, want.computed_sum);
			case (kind_t'(want.item_kind))
				KIND_GOOD: good_seen++;
				KIND_BAD:  bad_seen++;
				default:   payload_seen++;
			endcase
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	rspr_stream_if #(.payload_t(in_item_t))  rx_if ();
	rspr_stream_if #(.payload_t(out_item_t)) res_if ();

	rsp_packet_receiver_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if)
	);

	rsp_frame_scoreboard frame_sb = new();

	int unsigned cycle_count    = 0;
	int unsigned bytes_offered  = 0;  // every accepted byte, noise included
	int unsigned framed_bytes   = 0;  // bytes sent as part of a frame
	int unsigned burst_left     = 0;
	int unsigned hold_requests  = 0;  // raised by the stimulus
	int unsigned holds_served   = 0;  // counted by the result sink

	always #5 clk = ~clk;

	// Results are sampled on the rising edge; a transaction completes when
	// valid and ready are both high there.
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			frame_sb.check_result(res_if.payload);
		end
	end

	// Watchdog: a lost or stuck result would otherwise hang the drain loops.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d transactions still owed", cycle_count,
			frame_sb.owed_q.size());
		$display("Test completed with failures");
		$finish;
	end

	// Result side. Each stretch picks a stall pattern at random; a hold
	// request from the stimulus overrides it with a long run of ready low,
	// counted here, so the block backs up and stalls its input channel.
	initial begin : result_sink
		int mode;
		int unsigned left;
		int unsigned hold;
		mode = SINK_ALWAYS;
		left = 0;
		hold = 0;
		res_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold == 0 && holds_served < hold_requests) begin
				hold = LONG_HOLD;
				holds_served++;
			end
			if (left == 0) begin
				mode = $urandom_range(SINK_ALWAYS, SINK_PERIODIC);
				left = $urandom_range(8, 60);
			end
			left--;
			if (hold != 0) begin
				hold--;
				res_if.ready <= 1'b0;
			end else begin
				case (mode)
					SINK_HALF:     res_if.ready <= ($urandom_range(0, 1) == 1);
					SINK_SPARSE:   res_if.ready <= ($urandom_range(0, 3) == 0);
					SINK_PERIODIC: res_if.ready <= ((left % 3) != 0);
					default:       res_if.ready <= 1'b1;
				endcase
			end
		end
	end

	// Offers one byte and returns once it has been taken. Entered and left
	// just after a falling edge; the sender works in bursts with gaps of
	// random length between them, and a zero gap is common.
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				rx_if.valid <= 1'b0;
				@(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		rx_if.valid <= 1'b1;
		rx_if.payload.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		frame_sb.note_byte(b);
		bytes_offered++;
		burst_left--;
		@(negedge clk);
	endtask

	// Sender rests until every owed transaction has come out.
	task automatic idle_until_drained();
		rx_if.valid <= 1'b0;
		while (frame_sb.owed_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
		if (n < 4'd10) begin
			return 8'h30 + 8'(n);
		end
		return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] junk_digit();
		logic [7:0] c;
		logic [4:0] d;
		do begin
			c = 8'($urandom);
			d = frame_sb.hex_digit(c);
		end while (!d[4]);
		return c;
	endfunction

	// One packet on the link: a little noise, '$', payload, '#', two digits.
	// Most packets are well formed; a few end early, lose their '#' or carry
	// a wrong or malformed checksum.
	task automatic send_random_frame();
		int unsigned noise;
		int unsigned len;
		int unsigned pick;
		logic [7:0] sum;
		logic [7:0] b;
		logic [7:0] hi;
		logic [7:0] lo;
		noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (noise) send_byte(8'($urandom));
		len = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
		sum = '0;
		send_byte(START_CHAR);
		framed_bytes++;
		repeat (len) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				// escape pair; the escaped byte leans toward the framing codes
				case ($urandom_range(0, 5))
					0:       b = END_CHAR;
					1:       b = START_CHAR;
					2:       b = ESC_CHAR;
					default: b = 8'($urandom);
				endcase
				send_byte(ESC_CHAR);
				send_byte(b);
				sum = sum + ESC_CHAR + b;
				framed_bytes += 2;
			end else if (pick < 14) begin
				send_byte(START_CHAR);
				sum = sum + START_CHAR;
				framed_bytes++;
			end else if (pick < 15) begin
				// stray '#' cuts the frame short
				send_byte(END_CHAR);
				framed_bytes++;
			end else begin
				do b = 8'($urandom); while (b == END_CHAR || b == ESC_CHAR);
				send_byte(b);
				sum = sum + b;
				framed_bytes++;
			end
		end
		if ($urandom_range(0, 32) == 0) begin
			return;  // truncated: the next frame's bytes land in this one
		end
		send_byte(END_CHAR);
		pick = $urandom_range(0, 99);
		if (pick >= 75 && pick < 87) begin
			sum = sum + 8'($urandom_range(1, 255));
		end
		hi = hex_char(sum[7:4], 1'($urandom_range(0, 1)));
		lo = hex_char(sum[3:0], 1'($urandom_range(0, 1)));
		if (pick >= 87 && pick < 93) begin
			hi = junk_digit();
		end else if (pick >= 93 && pick < 97) begin
			lo = junk_digit();
		end else if (pick >= 97) begin
			hi = 8'($urandom);
			lo = 8'($urandom);
		end
		send_byte(hi);
		send_byte(lo);
		framed_bytes += 3;
	endtask

	initial begin : stimulus
		bit hold_asked;
		bit pause_taken;
		hold_asked  = 1'b0;
		pause_taken = 1'b0;
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.payload = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i]) begin
			send_byte(DIRECTED[i]);
		end
		idle_until_drained();

		while (framed_bytes < FRAMED_TARGET) begin
			// long result-side hold while the sender keeps offering
			if (!hold_asked && framed_bytes >= HOLD_AT) begin
				hold_requests++;
				hold_asked = 1'b1;
			end
			// and one pause with the sender waiting for the block to empty
			if (!pause_taken && framed_bytes >= PAUSE_AT) begin
				idle_until_drained();
				pause_taken = 1'b1;
			end
			send_random_frame();
		end

		idle_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d bytes (%0d inside frames) in %0d cycles", bytes_offered,
			framed_bytes, cycle_count);
		$display("Checked %0d payload bytes, %0d good and %0d bad frame ends, %0d mismatches",
			frame_sb.payload_seen, frame_sb.good_seen, frame_sb.bad_seen, frame_sb.mismatches);
		if (frame_sb.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/rspr_pkg.sv
hw/rtl/rspr_stream_if.sv
hw/rtl/rspr_parser.sv
hw/rtl/rsp_packet_receiver_top.sv
test/rsp_packet_receiver_top_tb.sv
